[hw/rtl/dual_motor_ramp_relay_reverse_macros.svh]
// Assertion macros shared by the ramp and relay block.
`ifndef DUAL_MOTOR_RAMP_RELAY_REVERSE_MACROS_SVH
`define DUAL_MOTOR_RAMP_RELAY_REVERSE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DMRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DMRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dmrr_pkg.sv]
// Types and constants of the dual motor ramp and relay block.
package dmrr_pkg;

    localparam int SPEED_W   = 9;
    localparam int STEP_W    = 7;
    localparam int WAIT_W    = 8;
    localparam int BOUND_W   = 8;
    localparam int CMP_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_BOUND = 2'd2;

    localparam logic [STEP_W-1:0]  RAMP_STEP_RST  = 7'd25;
    localparam logic [WAIT_W-1:0]  RELAY_WAIT_RST = 8'd7;
    localparam logic [BOUND_W-1:0] RAMP_BOUND_RST = 8'd127;

    localparam logic [CMP_W-1:0] COMPARE_OFF = 8'hFF;

    typedef struct packed {
        logic [STEP_W-1:0]  ramp_step;
        logic [WAIT_W-1:0]  relay_wait;
        logic [BOUND_W-1:0] ramp_bound;
    } t_cfg;

    typedef struct packed {
        logic [CMP_W-1:0] compare;
        logic             relay_dir;
        logic             settling;
    } t_lane_res;

endpackage

[hw/rtl/dmrr_lane.sv]
// One motor channel: slew-limited speed, relay reversal and settling count.
module dmrr_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dmrr_pkg::t_cfg                    i_cfg,
    input  logic                              i_en,
    input  logic signed [dmrr_pkg::SPEED_W-1:0] i_target,
    output dmrr_pkg::t_lane_res               o_res
);
    import dmrr_pkg::*;

    localparam int XW = SPEED_W + 2;

    logic signed [SPEED_W-1:0] r_speed, n_speed;
    logic                      r_wait, n_wait;
    logic [WAIT_W-1:0]         r_count, n_count;
    logic                      r_dir, n_dir;
    logic [CMP_W-1:0]          r_duty, n_duty;

    logic signed [XW-1:0] speed_x, tgt_x, step_x, bound_x, sum_x, next_x;
    logic [SPEED_W:0]     abs_next;
    logic [CMP_W-1:0]     mag;

    always_comb begin
        speed_x = XW'(r_speed);
        tgt_x   = XW'(i_target);
        step_x  = $signed({{(XW-STEP_W){1'b0}}, i_cfg.ramp_step});
        bound_x = $signed({{(XW-BOUND_W){1'b0}}, i_cfg.ramp_bound});
        sum_x   = speed_x;
        next_x  = speed_x;
        if (speed_x < tgt_x) begin
            sum_x = speed_x + step_x;
            if (sum_x < -bound_x) begin
                next_x = -bound_x;
            end else if (sum_x > tgt_x) begin
                next_x = tgt_x;
            end else begin
                next_x = sum_x;
            end
        end else if (speed_x > tgt_x) begin
            sum_x = speed_x - step_x;
            if (sum_x < tgt_x) begin
                next_x = tgt_x;
            end else if (sum_x > bound_x) begin
                next_x = bound_x;
            end else begin
                next_x = sum_x;
            end
        end
        // |2*next| saturates at 255 once |next| reaches 128
        abs_next = next_x[XW-1] ? (SPEED_W+1)'(0) - next_x[SPEED_W:0]
                                : next_x[SPEED_W:0];
        if (abs_next[SPEED_W:CMP_W-1] != '0) begin
            mag = COMPARE_OFF;
        end else begin
            mag = {abs_next[CMP_W-2:0], 1'b0};
        end

        n_speed = r_speed;
        n_wait  = r_wait;
        n_count = r_count;
        n_dir   = r_dir;
        n_duty  = r_duty;
        if (r_wait) begin
            if (r_count < i_cfg.relay_wait) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = '0;
                n_wait  = 1'b0;
            end
        end else begin
            n_speed = next_x[SPEED_W-1:0];
            if (r_speed[SPEED_W-1] != next_x[XW-1]) begin
                n_duty = COMPARE_OFF;
                n_dir  = ~r_dir;
                n_wait = 1'b1;
            end else begin
                n_duty = COMPARE_OFF - mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_wait  <= 1'b0;
            r_count <= '0;
            r_dir   <= 1'b0;
            r_duty  <= COMPARE_OFF;
        end else if (i_en) begin
            r_speed <= n_speed;
            r_wait  <= n_wait;
            r_count <= n_count;
            r_dir   <= n_dir;
            r_duty  <= n_duty;
        end
    end

    assign o_res.compare   = n_duty;
    assign o_res.relay_dir = n_dir;
    assign o_res.settling  = n_wait;

endmodule

[hw/rtl/dmrr_merge.sv]
// Merge stage: joins both lane results into one beat behind a skid register.
module dmrr_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dmrr_pkg::t_lane_res i_res_a,
    input  dmrr_pkg::t_lane_res i_res_b,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output dmrr_pkg::t_lane_res o_res_a,
    output dmrr_pkg::t_lane_res o_res_b
);
    import dmrr_pkg::*;

    logic      r_valid, r_skid_valid;
    t_lane_res r_main_a, r_main_b, r_skid_a, r_skid_b;
    logic      pop;

    assign pop = r_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // upstream is held off; drain the skid into the main slot
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid || pop) begin
                r_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main_a <= r_skid_a;
                r_main_b <= r_skid_b;
            end
        end else if (i_push) begin
            if (!r_valid || pop) begin
                r_main_a <= i_res_a;
                r_main_b <= i_res_b;
            end else begin
                r_skid_a <= i_res_a;
                r_skid_b <= i_res_b;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_res_a = r_main_a;
    assign o_res_b = r_main_b;

endmodule

[hw/rtl/dual_motor_ramp_relay_reverse.sv]
// Top level of the dual motor slew limiter with relay reversal dead time.
//
// Usage:
//   Input channel: one beat per timer tick carries i_target_a and
//   i_target_b; it is taken on a rising edge with i_valid high and
//   o_stall low. Output channel: one beat per input beat carries the
//   compare, relay direction and settling flag of both motors; it is
//   taken on a rising edge with o_valid high and i_stall low.
//   Both motors run in lanes of their own, side by side, and the merge
//   stage packs their results into one output beat.
//   Registers: each result lands in the merge output slot, or in the skid while that slot is held.
//   Throughput: one beat per cycle while o_stall is low; each lane updates its speed, count
//   and relay state in a single add-clamp-compare step per beat.
//   Stall: a skid register behind the output slot absorbs one extra beat,
//   so o_stall rises only when both slots hold results; it falls as soon
//   as the receiver takes a beat.
//   Reset (i_rst_n low, synchronous): speeds zero, run mode, relays at 0,
//   compares at 255 (off), output empty, registers at their defaults.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we
//   is high; write only while the block is idle. Unused indexes are ignored.
module dual_motor_ramp_relay_reverse (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dmrr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dmrr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [dmrr_pkg::SPEED_W-1:0]  i_target_a,
    input  logic signed [dmrr_pkg::SPEED_W-1:0]  i_target_b,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [dmrr_pkg::CMP_W-1:0]           o_compare_a,
    output logic [dmrr_pkg::CMP_W-1:0]           o_compare_b,
    output logic                                 o_relay_dir_a,
    output logic                                 o_relay_dir_b,
    output logic                                 o_settling_a,
    output logic                                 o_settling_b
);
    import dmrr_pkg::*;

    `include "dual_motor_ramp_relay_reverse_macros.svh"

    t_cfg      r_cfg;
    t_lane_res res_a, res_b, out_a, out_b;
    logic      accept;
    logic      full;

    // Hold configuration registers; ignore writes to unused indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step  <= RAMP_STEP_RST;
            r_cfg.relay_wait <= RELAY_WAIT_RST;
            r_cfg.ramp_bound <= RAMP_BOUND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RAMP_STEP:  r_cfg.ramp_step  <= i_cfg_data[STEP_W-1:0];
                REG_RELAY_WAIT: r_cfg.relay_wait <= i_cfg_data[WAIT_W-1:0];
                REG_RAMP_BOUND: r_cfg.ramp_bound <= i_cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance both lanes on every accepted beat.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    dmrr_lane u_lane_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_en     (accept),
        .i_target (i_target_a),
        .o_res    (res_a)
    );

    dmrr_lane u_lane_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_en     (accept),
        .i_target (i_target_b),
        .o_res    (res_b)
    );

    dmrr_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res_a (res_a),
        .i_res_b (res_b),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res_a (out_a),
        .o_res_b (out_b)
    );

    assign o_compare_a   = out_a.compare;
    assign o_compare_b   = out_b.compare;
    assign o_relay_dir_a = out_a.relay_dir;
    assign o_relay_dir_b = out_b.relay_dir;
    assign o_settling_a  = out_a.settling;
    assign o_settling_b  = out_b.settling;

    // A beat taken while the output slot is stuck must land in the skid.
    `DMRR_ASSERT_NEXT(a_skid_fill, i_valid && !o_stall && o_valid && i_stall, o_stall, "skid not filled")
    // A settling motor is always shown switched off.
    `DMRR_ASSERT_NOW(a_off_a, o_valid && o_settling_a, o_compare_a == COMPARE_OFF, "motor A on while settling")
    `DMRR_ASSERT_NOW(a_off_b, o_valid && o_settling_b, o_compare_b == COMPARE_OFF, "motor B on while settling")

endmodule
